// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, opcodes, status codes and sequencer states of the
// stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_MOD  = 4'd5;
  localparam logic [3:0] OP_POP  = 4'd6;
  localparam logic [3:0] OP_AND  = 4'd8;
  localparam logic [3:0] OP_OR   = 4'd9;
  localparam logic [3:0] OP_NOT  = 4'd10;
  localparam logic [3:0] OP_HALT = 4'd11;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_TOP,
    S_RD_NEXT,
    S_DIV,
    S_DONE
  } smx_state_t;

endpackage

// ===== rtl/smx_ram.sv =====
// ----------------------------------------------------------------------------
// smx_ram
// Generic simple dual-port RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div
// Iterative signed divider, one quotient bit per cycle. Quotient and
// remainder truncate toward zero.
// ----------------------------------------------------------------------------
module smx_div import smx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvsr_r, dvsr_nxt;
  logic                 neg_q_r, neg_q_nxt;
  logic                 neg_r_r, neg_r_nxt;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvsr_r  <= dvsr_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvsr_nxt  = dvsr_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    rem_shift = {rem_r, quo_r[DATA_W-1]};
    diff      = rem_shift - {1'b0, dvsr_r};
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvsr_nxt  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_q_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_nxt = dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (~quo_r + 1'b1) : quo_r;
  assign remainder = neg_r_r ? (~rem_r + 1'b1) : rem_r;

endmodule

// ===== rtl/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor
// 32-bit stack machine that executes one instruction per input transfer.
//
// The input channel (in_valid, in_stall, in_mode, in_immediate) takes one
// instruction at a time; in_stall is low only while the sequencer is idle.
// Every instruction gives exactly one result transfer on the output channel
// (out_valid, out_stall, out_status, out_popped_valid, out_popped_value).
// The stack lives in a RAM with a registered read, and the
// sequencer reads, modifies and writes back its top entries.
// Push, halt and no-op codes and errors found at decode go from idle
// straight to the done state; pop and not first read the top entry; the
// other binary operations read two entries, and divide and modulo by a
// nonzero divisor use the 32-step iterative divider. The next instruction is
// taken in the cycle after the result is loaded into the output register,
// so a new transfer can start while an earlier result still waits there.
// A stalled receiver holds the result in the output register; a second
// result waits in the sequencer until the register frees.
// Reset empties the stack and clears the halted state; the RAM contents
// are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_executor import smx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_immediate,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic                     out_popped_valid,
  output logic signed [DATA_W-1:0] out_popped_value
);

  smx_state_t        state_r, state_nxt;
  logic [3:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              halted_r, halted_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  logic              res_pv_r, res_pv_nxt;
  logic [DATA_W-1:0] res_pval_r, res_pval_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic              out_pv_r, out_pv_nxt;
  logic [DATA_W-1:0] out_pval_r, out_pval_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] prod;
  logic              is_binary;

  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mem_rdata),
    .divisor   (a_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    a_r          <= a_nxt;
    res_status_r <= res_status_nxt;
    res_pv_r     <= res_pv_nxt;
    res_pval_r   <= res_pval_nxt;
    out_status_r <= out_status_nxt;
    out_pv_r     <= out_pv_nxt;
    out_pval_r   <= out_pval_nxt;
  end

  assign cnt_m1 = count_r - CNT_W'(1);
  assign cnt_m2 = count_r - CNT_W'(2);
  assign prod   = mem_rdata * a_r;

  always_comb begin
    case (in_mode)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: is_binary = 1'b1;
      default: is_binary = 1'b0;
    endcase
  end

  always_comb begin
    case (mode_r)
      OP_ADD:  alu_res = mem_rdata + a_r;
      OP_SUB:  alu_res = mem_rdata - a_r;
      OP_MUL:  alu_res = prod;
      OP_AND:  alu_res = mem_rdata & a_r;
      OP_OR:   alu_res = mem_rdata | a_r;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    halted_nxt     = halted_r;
    a_nxt          = a_r;
    res_status_nxt = res_status_r;
    res_pv_nxt     = res_pv_r;
    res_pval_nxt   = res_pval_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pv_nxt     = out_pv_r;
    out_pval_nxt   = out_pval_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_m2[ADDR_W-1:0];
    mem_wdata      = alu_res;
    mem_raddr      = cnt_m1[ADDR_W-1:0];
    div_start      = 1'b0;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt       = in_mode;
          res_status_nxt = ST_OK;
          res_pv_nxt     = 1'b0;
          res_pval_nxt   = '0;
          state_nxt      = S_DONE;
          if (halted_r) begin
            res_status_nxt = ST_HALTED;
          end else if (in_mode == OP_PUSH) begin
            if (count_r == CNT_W'(STACK_DEPTH)) begin
              res_status_nxt = ST_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[ADDR_W-1:0];
              mem_wdata = in_immediate;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (in_mode == OP_POP || in_mode == OP_NOT) begin
            if (count_r == '0) begin
              res_status_nxt = ST_UNDERFLOW;
            end else begin
              state_nxt = S_RD_TOP;
            end
          end else if (in_mode == OP_HALT) begin
            res_status_nxt = ST_HALTED;
          end else if (is_binary) begin
            if (count_r < CNT_W'(2)) begin
              res_status_nxt = ST_UNDERFLOW;
            end else begin
              state_nxt = S_RD_TOP;
            end
          end
        end
      end
      S_RD_TOP: begin
        if (mode_r == OP_POP) begin
          res_pv_nxt   = 1'b1;
          res_pval_nxt = mem_rdata;
          count_nxt    = cnt_m1;
          state_nxt    = S_DONE;
        end else if (mode_r == OP_NOT) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[ADDR_W-1:0];
          mem_wdata = (mem_rdata == '0) ? DATA_W'(1) : '0;
          state_nxt = S_DONE;
        end else begin
          a_nxt     = mem_rdata;
          mem_raddr = cnt_m2[ADDR_W-1:0];
          state_nxt = S_RD_NEXT;
        end
      end
      S_RD_NEXT: begin
        if (mode_r == OP_DIV || mode_r == OP_MOD) begin
          if (a_r == '0) begin
            res_status_nxt = ST_DIVZERO;
            state_nxt      = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else begin
          mem_we    = 1'b1;
          count_nxt = cnt_m1;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = (mode_r == OP_DIV) ? div_quo : div_rem;
          count_nxt = cnt_m1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pv_nxt     = res_pv_r;
          out_pval_nxt   = res_pval_r;
          if (res_status_r != ST_OK) begin
            halted_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_valid = out_pv_r;
  assign out_popped_value = out_pval_r;

endmodule

// ===== tb/stack_machine_executor_test.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor_test
// Runs instruction streams through the stack machine executor and checks
// every result transfer against a shadow stack kept in the bench. A short
// directed program covers wrap-around and truncation corners, then random
// programs drive the stack between empty and full with bursty input and a
// stalling receiver. One error case, chosen at random, closes the run,
// followed by a few instructions that must all report halted.
// ----------------------------------------------------------------------------
module stack_machine_executor_test;
  import smx_pkg::*;

  localparam logic [3:0] OP_SPARE_7  = 4'd7;
  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic              drain;
    logic [3:0]        mode;
    logic [DATA_W-1:0] imm;
  } instr_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              popped_valid;
    logic [DATA_W-1:0] popped_value;
  } outcome_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_mode = '0;
  logic signed [DATA_W-1:0] in_immediate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic out_popped_valid;
  logic signed [DATA_W-1:0] out_popped_value;

  instr_t   program_queue[$];
  outcome_t predicted_outcomes[$];
  instr_t   next_instr;
  outcome_t oldest;

  logic [DATA_W-1:0] shadow_stack [0:STACK_DEPTH-1];
  int  shadow_depth = 0;
  bit  shadow_halted = 1'b0;
  int  deepest = 0;

  int  gen_depth = 0;
  bit  drain_next = 1'b0;
  int  total_items = 0;

  logic in_fire = 1'b0;
  int  accepted_count = 0;
  int  checked_count = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;
  int  seg_left = 0;
  int  stall_pct = 0;

  stack_machine_executor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_immediate     (in_immediate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_valid (out_popped_valid),
    .out_popped_value (out_popped_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void step_stack_model(input logic [3:0] op, input logic [DATA_W-1:0] imm);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] r;
    outcome_t res;
    res.status = ST_OK;
    res.popped_valid = 1'b0;
    res.popped_value = '0;
    r = '0;
    if (shadow_halted) begin
      res.status = ST_HALTED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (shadow_depth >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            shadow_stack[shadow_depth] = imm;
            shadow_depth++;
          end
        end
        OP_POP: begin
          if (shadow_depth == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            shadow_depth--;
            res.popped_valid = 1'b1;
            res.popped_value = shadow_stack[shadow_depth];
          end
        end
        OP_NOT: begin
          if (shadow_depth == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            shadow_stack[shadow_depth-1] = (shadow_stack[shadow_depth-1] == '0) ? 32'd1 : 32'd0;
          end
        end
        OP_HALT: begin
          res.status = ST_HALTED;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: begin
          if (shadow_depth < 2) begin
            res.status = ST_UNDERFLOW;
          end else begin
            a = shadow_stack[shadow_depth-1];
            b = shadow_stack[shadow_depth-2];
            ma = a[DATA_W-1] ? -a : a;
            mb = b[DATA_W-1] ? -b : b;
            if ((op == OP_DIV || op == OP_MOD) && a == '0) begin
              res.status = ST_DIVZERO;
            end else begin
              case (op)
                OP_ADD: r = b + a;
                OP_SUB: r = b - a;
                OP_MUL: r = b * a;
                OP_DIV: begin
                  r = mb / ma;
                  if (a[DATA_W-1] ^ b[DATA_W-1]) r = -r;
                end
                OP_MOD: begin
                  r = mb % ma;
                  if (b[DATA_W-1]) r = -r;
                end
                OP_AND: r = b & a;
                default: r = b | a;
              endcase
              shadow_depth--;
              shadow_stack[shadow_depth-1] = r;
            end
          end
        end
        default: ;
      endcase
    end
    if (res.status != ST_OK) shadow_halted = 1'b1;
    if (shadow_depth > deepest) deepest = shadow_depth;
    predicted_outcomes.push_back(res);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_binary(input bit with_div);
    case ($urandom_range(0, with_div ? 6 : 4))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      3: return OP_AND;
      4: return OP_OR;
      5: return OP_DIV;
      default: return OP_MOD;
    endcase
  endfunction

  // Queues one instruction and tracks the stack depth it leaves, assuming no error.
  task automatic add_op(input logic [3:0] op, input logic [DATA_W-1:0] value);
    instr_t it;
    it.drain = drain_next;
    it.mode = op;
    it.imm = value;
    drain_next = 1'b0;
    program_queue.push_back(it);
    total_items++;
    case (op)
      OP_PUSH: gen_depth++;
      OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: gen_depth--;
      default: ;
    endcase
  endtask

  // Input driver: one transfer per accepted item, bursts separated by gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (program_queue.size() == 0 ||
                   (program_queue[0].drain && predicted_outcomes.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_instr = program_queue.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_instr.mode;
        in_immediate <= next_instr.imm;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: one long hold-off once traffic is flowing, otherwise stall segments.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_count >= 300) begin
      hold_done = 1'b1;
      hold_cycles = 300;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        step_stack_model(in_mode, in_immediate);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        checked_count++;
        if (predicted_outcomes.size() == 0) begin
          $error("unexpected result transfer: status %0d", out_status);
          fail_count++;
        end else begin
          oldest = predicted_outcomes.pop_front();
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            fail_count++;
          end
          if (out_popped_valid !== oldest.popped_valid) begin
            $error("popped_valid: expected %0d, got %0d", oldest.popped_valid,
                   out_popped_valid);
            fail_count++;
          end
          if (out_popped_value !== oldest.popped_value) begin
            $error("popped_value: expected %h, got %h", oldest.popped_value,
                   out_popped_value);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stack_machine_executor: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    int target;
    int r;
    int s;
    int trailing;
    string closing_case;

    // Wrap-around, truncation and minimum-by-minus-one corners.
    add_op(OP_PUSH, 32'h7FFF_FFFF);
    add_op(OP_PUSH, 32'd1);
    add_op(OP_ADD, $urandom);
    add_op(OP_PUSH, 32'hFFFF_FFFF);
    add_op(OP_DIV, $urandom);
    add_op(OP_PUSH, 32'hFFFF_FFFF);
    add_op(OP_MOD, $urandom);
    add_op(OP_NOT, $urandom);
    add_op(OP_NOT, $urandom);
    add_op(OP_PUSH, 32'h8000_0000);
    add_op(OP_SUB, $urandom);
    add_op(OP_PUSH, 32'hFFFF_FFFF);
    add_op(OP_MUL, $urandom);
    add_op(OP_PUSH, 32'hFFFF_FFF9);
    add_op(OP_PUSH, 32'd2);
    add_op(OP_MOD, $urandom);
    add_op(OP_AND, $urandom);
    add_op(OP_PUSH, 32'd5);
    add_op(OP_OR, $urandom);
    add_op(OP_PUSH, 32'hFFFF_FFF7);
    add_op(OP_PUSH, 32'd2);
    add_op(OP_DIV, $urandom);
    add_op(OP_SPARE_7, $urandom);
    add_op(OP_SPARE_LO, $urandom);
    add_op(OP_POP, $urandom);
    add_op(OP_POP, $urandom);

    target = 0;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 150 == 0)
        target = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 256) : $urandom_range(2, 40);
      if (n >= 200 && n < 600) target = STACK_DEPTH;
      if (n == 450 || $urandom_range(0, 99) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_op(($urandom_range(0, 4) == 0) ? OP_SPARE_7 : OP_SPARE_LO + 4'($urandom_range(0, 3)),
               $urandom);
      end else if (gen_depth < STACK_DEPTH &&
                   (gen_depth == 0 || r < ((gen_depth < target) ? 90 : 25))) begin
        add_op(OP_PUSH, pick_operand());
      end else begin
        s = $urandom_range(0, 9);
        if (s < 2) begin
          add_op(OP_POP, $urandom);
        end else if (s == 2) begin
          add_op(OP_NOT, $urandom);
        end else if (s == 3 && gen_depth < STACK_DEPTH) begin
          // A divisor pushed just before keeps the divide away from zero.
          r = 0;
          while (r == 0) r = pick_operand();
          add_op(OP_PUSH, r);
          add_op(($urandom_range(0, 1) == 0) ? OP_DIV : OP_MOD, $urandom);
          n++;
        end else if (gen_depth >= 2) begin
          add_op(pick_binary(1'b0), $urandom);
        end else begin
          add_op(OP_POP, $urandom);
        end
      end
      n++;
    end

    // Every error halts the machine for good, so one error case ends the run.
    case ($urandom_range(0, 6))
      0: begin
        closing_case = "stack overflow";
        while (gen_depth < STACK_DEPTH) add_op(OP_PUSH, pick_operand());
        add_op(OP_PUSH, pick_operand());
      end
      1: begin
        closing_case = "pop underflow";
        while (gen_depth > 0) add_op(OP_POP, $urandom);
        add_op(OP_POP, $urandom);
      end
      2: begin
        closing_case = "logical not underflow";
        while (gen_depth > 0) add_op(OP_POP, $urandom);
        add_op(OP_NOT, $urandom);
      end
      3: begin
        closing_case = "binary operation underflow";
        while (gen_depth > $urandom_range(0, 1)) add_op(OP_POP, $urandom);
        add_op(pick_binary(1'b1), $urandom);
      end
      4, 5: begin
        closing_case = "zero divisor";
        if (gen_depth == STACK_DEPTH) add_op(OP_POP, $urandom);
        if (gen_depth == 0) add_op(OP_PUSH, pick_operand());
        add_op(OP_PUSH, 32'd0);
        add_op((gen_depth % 2 == 0) ? OP_DIV : OP_MOD, $urandom);
      end
      default: begin
        closing_case = "halt instruction";
        add_op(OP_HALT, $urandom);
      end
    endcase
    trailing = $urandom_range(4, 10);
    for (int i = 0; i < trailing; i++) add_op(4'($urandom_range(0, 15)), pick_operand());

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items || predicted_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d instructions; deepest stack %0d of %0d entries.",
             checked_count, accepted_count, deepest, STACK_DEPTH);
    $display("Closed with the %s case, then %0d instructions against the halted machine.",
             closing_case, trailing);
    if (fail_count == 0) begin
      $display("stack_machine_executor: match");
    end else begin
      $display("stack_machine_executor: mismatch");
    end
    $finish;
  end

endmodule
